[hw/rtl/pdpa_pkg.sv]
// ----------------------------------------------------------------------------
// pdpa_pkg
// Shared types and constants of the per-destination packet aggregator.
// ----------------------------------------------------------------------------
package pdpa_pkg;

    localparam logic [1:0] STATUS_SENT       = 2'd0;
    localparam logic [1:0] STATUS_TABLE_FULL = 2'd1;
    localparam logic [1:0] STATUS_QUEUE_FULL = 2'd2;

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    localparam logic [0:0] REG_SEND_DELAY = 1'd0;
    localparam logic [0:0] REG_MAX_AGG    = 1'd1;

    localparam int MAX_RESULTS = 64;
    localparam int MAX_AGG     = 8;

    // One result item as it travels to the output register.
    typedef struct packed {
        logic [31:0] dest;
        logic [15:0] handle;
        logic [15:0] length;
        logic [18:0] total;
        logic        last;
        logic        bundled;
        logic [1:0]  status;
    } result_t;

endpackage

[hw/rtl/pdpa_out_reg.sv]
// ----------------------------------------------------------------------------
// pdpa_out_reg
// Single output register with a valid/stall handshake.
// ----------------------------------------------------------------------------
module pdpa_out_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  pdpa_pkg::result_t  load_data,
    output logic               free,
    output logic               out_valid,
    input  logic               out_stall,
    output pdpa_pkg::result_t  out_data
);

    logic              valid_reg;
    pdpa_pkg::result_t data_reg;

    // The slot is free when empty or being taken this cycle.
    assign free      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Valid flag of the output slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload of the output slot.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

[hw/rtl/per_destination_packet_aggregator_top.sv]
// ----------------------------------------------------------------------------
// per_destination_packet_aggregator_top
// Rate-limits packets per destination and bundles held packets into
// aggregates, driven by packet items and tick items.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  kind, dest_address, packet_handle,
//                                          byte_length
//   out      output     out_valid/out_stall out_dest ... status
//   cfg      input      APB write/read     send_delay_ticks, max_per_aggregate
//
// The block works on one item at a time. A pass-through packet is accepted
// and then emitted. Any other packet is accepted, searches the table entry
// by entry up to its match, resolves the entry and decides, and then reads
// the head and emits for each result item. A tick sweeps the whole table
// once per destination in key order, drains each due queue with a head read
// and an emit per result item, and ends with one last sweep. Reset clears
// the valid bits, queue state and time at once; no clearing pass is needed.
// A stalled output holds the sequencer in place.
// ----------------------------------------------------------------------------
module per_destination_packet_aggregator_top
#(
    parameter int NUM_DESTINATIONS = 8,
    parameter int QUEUE_DEPTH      = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [31:0] dest_address,
    input  logic [15:0] packet_handle,
    input  logic [15:0] byte_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_dest,
    output logic [15:0] out_handle,
    output logic [15:0] out_length,
    output logic [18:0] total_bytes,
    output logic        last_of_aggregate,
    output logic        bundled,
    output logic [1:0]  status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DW = (NUM_DESTINATIONS > 1) ? $clog2(NUM_DESTINATIONS) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int HDEPTH = NUM_DESTINATIONS * QUEUE_DEPTH;
    localparam int HW = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
    localparam int KW = $clog2(pdpa_pkg::MAX_RESULTS + 1);
    localparam logic [DW-1:0] LAST_D = DW'(NUM_DESTINATIONS - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PSCAN  = 4'd1;
    localparam logic [3:0] S_PRD    = 4'd2;
    localparam logic [3:0] S_PDEC   = 4'd3;
    localparam logic [3:0] S_DRAIN  = 4'd4;
    localparam logic [3:0] S_DWAIT  = 4'd5;
    localparam logic [3:0] S_TSCAN  = 4'd6;
    localparam logic [3:0] S_TRD    = 4'd7;
    localparam logic [3:0] S_TDEC   = 4'd8;
    localparam logic [3:0] S_EMIT1  = 4'd9;

    // Configuration registers.
    logic [15:0] delay_reg;
    logic [3:0]  maxagg_reg;
    logic        wr_en;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg  <= '0;
            maxagg_reg <= 4'd8;
        end
        else if (wr_en && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == pdpa_pkg::REG_SEND_DELAY)
            begin
                delay_reg <= pwdata[15:0];
            end
            else
            begin
                maxagg_reg <= pwdata[3:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        case (paddr[2])
            pdpa_pkg::REG_SEND_DELAY: prdata = {16'd0, delay_reg};
            default:                  prdata = {28'd0, maxagg_reg};
        endcase
    end

    // Effective aggregate limit, clamped to 1..8.
    logic [3:0] agg_lim;
    always_comb
    begin
        agg_lim = maxagg_reg;
        if (maxagg_reg == 4'd0)
        begin
            agg_lim = 4'd1;
        end
        else if (maxagg_reg > 4'd8)
        begin
            agg_lim = 4'd8;
        end
    end

    // Small per-entry flip-flop state, reset at once.
    logic [NUM_DESTINATIONS-1:0] dvalid_reg;
    logic [QW-1:0] qhead_reg [NUM_DESTINATIONS];
    logic [CW-1:0] qcount_reg [NUM_DESTINATIONS];
    logic [31:0]   now_reg;

    // Destination memory: key and last send time, one read port.
    logic [63:0]   dmem [NUM_DESTINATIONS];
    logic [DW-1:0] dmem_raddr;
    logic [63:0]   dmem_rdata;
    logic          dmem_we;
    logic [DW-1:0] dmem_waddr;
    logic [63:0]   dmem_wdata;
    always_ff @(posedge clk)
    begin
        if (dmem_we)
        begin
            dmem[dmem_waddr] <= dmem_wdata;
        end
        dmem_rdata <= dmem[dmem_raddr];
    end

    // Held packet memory: handle and length.
    logic [31:0]   hmem [HDEPTH];
    logic [HW-1:0] hmem_raddr;
    logic [31:0]   hmem_rdata;
    logic          hmem_we;
    logic [HW-1:0] hmem_waddr;
    logic [31:0]   hmem_wdata;
    always_ff @(posedge clk)
    begin
        if (hmem_we)
        begin
            hmem[hmem_waddr] <= hmem_wdata;
        end
        hmem_rdata <= hmem[hmem_raddr];
    end

    // Sequencer registers.
    logic [3:0]    state_reg, state_next;
    logic          kind_reg;
    logic [31:0]   dst_reg;
    logic [15:0]   h_reg, len_reg;
    logic [DW-1:0] idx_reg, idx_next;
    logic          found_reg, found_next;
    logic [DW-1:0] fidx_reg, fidx_next;
    logic          free_ok_reg, free_ok_next;
    logic [DW-1:0] free_reg, free_next;
    logic          have_prev_reg, have_prev_next;
    logic [31:0]   prev_reg, prev_next;
    logic          best_ok_reg, best_ok_next;
    logic [31:0]   best_key_reg, best_key_next;
    logic [DW-1:0] best_reg, best_next;
    logic [DW-1:0] cur_reg, cur_next;
    logic [31:0]   cur_key_reg, cur_key_next;
    logic [3:0]    n_reg, n_next;
    logic [3:0]    i_reg, i_next;
    logic [18:0]   tot_reg, tot_next;
    logic [KW-1:0] k_reg, k_next;
    logic          rd_pend_reg, rd_pend_next;

    logic              ob_load, ob_free;
    pdpa_pkg::result_t ob_data, ob_q;

    pdpa_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (ob_load),
        .load_data (ob_data),
        .free      (ob_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (ob_q)
    );
    assign out_dest          = ob_q.dest;
    assign out_handle        = ob_q.handle;
    assign out_length        = ob_q.length;
    assign total_bytes       = ob_q.total;
    assign last_of_aggregate = ob_q.last;
    assign bundled           = ob_q.bundled;
    assign status            = ob_q.status;

    assign in_stall = (state_reg != S_IDLE);

    // Due test on the destination word just read.
    logic [31:0] diff;
    assign diff = now_reg - (dmem_rdata[31:0] + {16'd0, delay_reg});

    logic [3:0] size_cur;
    logic [CW-1:0] cnt_cur;
    assign cnt_cur  = qcount_reg[cur_reg];
    assign size_cur = ({{(8 - CW){1'b0}}, cnt_cur} < {4'd0, agg_lim}) ?
                      4'(cnt_cur) : agg_lim;

    logic [QW-1:0] tail_pos;
    logic [QW:0]   tail_sum;
    assign tail_sum = {1'b0, qhead_reg[cur_reg]} + (QW+1)'(qcount_reg[cur_reg]);
    assign tail_pos = (tail_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                      QW'(tail_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(tail_sum);

    // Control flow.
    logic drain_step, enq, new_entry;
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        fidx_next      = fidx_reg;
        free_ok_next   = free_ok_reg;
        free_next      = free_reg;
        have_prev_next = have_prev_reg;
        prev_next      = prev_reg;
        best_ok_next   = best_ok_reg;
        best_key_next  = best_key_reg;
        best_next      = best_reg;
        cur_next       = cur_reg;
        cur_key_next   = cur_key_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        tot_next       = tot_reg;
        k_next         = k_reg;
        rd_pend_next   = 1'b0;
        dmem_raddr     = idx_reg;
        dmem_we        = 1'b0;
        dmem_waddr     = cur_reg;
        dmem_wdata     = {cur_key_reg, now_reg};
        hmem_raddr     = HW'({{(HW+DW){1'b0}}, cur_reg} * QUEUE_DEPTH
                         + {{HW{1'b0}}, qhead_reg[cur_reg]});
        hmem_we        = 1'b0;
        hmem_waddr     = HW'({{(HW+DW){1'b0}}, cur_reg} * QUEUE_DEPTH
                         + {{HW{1'b0}}, tail_pos});
        hmem_wdata     = {h_reg, len_reg};
        ob_load        = 1'b0;
        ob_data        = '0;
        drain_step     = 1'b0;
        enq            = 1'b0;
        new_entry      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next       = '0;
                    found_next     = 1'b0;
                    free_ok_next   = 1'b0;
                    have_prev_next = 1'b0;
                    best_ok_next   = 1'b0;
                    k_next         = '0;
                    if (kind == pdpa_pkg::KIND_TICK)
                    begin
                        state_next = S_TSCAN;
                        dmem_raddr = '0;
                        rd_pend_next = 1'b1;
                    end
                    else if (delay_reg == 16'd0)
                    begin
                        state_next = S_EMIT1;
                    end
                    else
                    begin
                        state_next = S_PSCAN;
                        dmem_raddr = '0;
                        rd_pend_next = 1'b1;
                    end
                end
            end

            // Pass-through: one result with the packet as is.
            S_EMIT1:
            begin
                if (ob_free)
                begin
                    ob_load = 1'b1;
                    ob_data = '{dest: dst_reg, handle: h_reg, length: len_reg,
                                total: {3'd0, len_reg}, last: 1'b1, bundled: 1'b0,
                                status: pdpa_pkg::STATUS_SENT};
                    state_next = S_IDLE;
                end
            end

            // Packet lookup: one entry per cycle, key from memory.
            S_PSCAN:
            begin
                if (rd_pend_reg)
                begin
                    if (dvalid_reg[idx_reg] && !found_reg)
                    begin
                        if (dmem_rdata[63:32] == dst_reg)
                        begin
                            found_next = 1'b1;
                            fidx_next  = idx_reg;
                        end
                    end
                    else if (!dvalid_reg[idx_reg] && !free_ok_reg)
                    begin
                        free_ok_next = 1'b1;
                        free_next    = idx_reg;
                    end
                    if (idx_reg == LAST_D ||
                        (dvalid_reg[idx_reg] && dmem_rdata[63:32] == dst_reg))
                    begin
                        state_next = S_PRD;
                    end
                    else
                    begin
                        idx_next     = idx_reg + 1'b1;
                        dmem_raddr   = idx_reg + 1'b1;
                        rd_pend_next = 1'b1;
                    end
                end
                else
                begin
                    rd_pend_next = 1'b1;
                end
            end

            // Resolve the entry and read its last send time, or report a full table.
            S_PRD:
            begin
                if (found_reg)
                begin
                    cur_next   = fidx_reg;
                    dmem_raddr = fidx_reg;
                    state_next = S_PDEC;
                end
                else if (free_ok_reg)
                begin
                    cur_next   = free_reg;
                    state_next = S_PDEC;
                end
                else if (ob_free)
                begin
                    ob_load = 1'b1;
                    ob_data = '{dest: dst_reg, handle: h_reg, length: len_reg,
                                total: 19'd0, last: 1'b1, bundled: 1'b0,
                                status: pdpa_pkg::STATUS_TABLE_FULL};
                    state_next = S_IDLE;
                end
            end

            // Queue full check, enqueue, decide on sending.
            S_PDEC:
            begin
                cur_key_next = dst_reg;
                if (found_reg && qcount_reg[cur_reg] >= CW'(QUEUE_DEPTH))
                begin
                    if (ob_free)
                    begin
                        ob_load = 1'b1;
                        ob_data = '{dest: dst_reg, handle: h_reg, length: len_reg,
                                    total: 19'd0, last: 1'b1, bundled: 1'b0,
                                    status: pdpa_pkg::STATUS_QUEUE_FULL};
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    enq = 1'b1;
                    hmem_we = 1'b1;
                    if (!found_reg)
                    begin
                        new_entry  = 1'b1;
                        dmem_we    = 1'b1;
                        dmem_wdata = {dst_reg, now_reg};
                        n_next     = 4'd1;
                        i_next     = '0;
                        tot_next   = '0;
                        state_next = S_DRAIN;
                    end
                    else if (diff != 32'd0 && !diff[31])
                    begin
                        n_next = ({{(8 - CW){1'b0}}, qcount_reg[cur_reg]} + 8'd1
                                  < {4'd0, agg_lim}) ?
                                 4'(qcount_reg[cur_reg] + 1'b1) : agg_lim;
                        i_next     = '0;
                        tot_next   = '0;
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            // Drain: read head, then emit when the output slot frees.
            S_DRAIN:
            begin
                state_next = S_DWAIT;
            end

            S_DWAIT:
            begin
                if (ob_free)
                begin
                    ob_load = 1'b1;
                    ob_data = '{dest: cur_key_reg, handle: hmem_rdata[31:16],
                                length: hmem_rdata[15:0],
                                total: (i_reg + 1'b1 == n_reg) ?
                                       tot_reg + {3'd0, hmem_rdata[15:0]} : 19'd0,
                                last: (i_reg + 1'b1 == n_reg), bundled: 1'b1,
                                status: pdpa_pkg::STATUS_SENT};
                    drain_step = 1'b1;
                    tot_next   = tot_reg + {3'd0, hmem_rdata[15:0]};
                    i_next     = i_reg + 1'b1;
                    k_next     = k_reg + 1'b1;
                    if (i_reg + 1'b1 == n_reg)
                    begin
                        dmem_we    = 1'b1;
                        if (kind_reg == pdpa_pkg::KIND_TICK)
                        begin
                            idx_next     = '0;
                            best_ok_next = 1'b0;
                            dmem_raddr   = '0;
                            rd_pend_next = 1'b1;
                            state_next   = S_TSCAN;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end

            // Tick: find the smallest key above the previous one.
            S_TSCAN:
            begin
                if (rd_pend_reg)
                begin
                    if (dvalid_reg[idx_reg] &&
                        (!have_prev_reg || dmem_rdata[63:32] > prev_reg) &&
                        (!best_ok_reg || dmem_rdata[63:32] < best_key_reg))
                    begin
                        best_ok_next  = 1'b1;
                        best_key_next = dmem_rdata[63:32];
                        best_next     = idx_reg;
                    end
                    if (idx_reg == LAST_D)
                    begin
                        state_next = S_TRD;
                    end
                    else
                    begin
                        idx_next     = idx_reg + 1'b1;
                        dmem_raddr   = idx_reg + 1'b1;
                        rd_pend_next = 1'b1;
                    end
                end
                else
                begin
                    rd_pend_next = 1'b1;
                end
            end

            S_TRD:
            begin
                if (!best_ok_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    have_prev_next = 1'b1;
                    prev_next      = best_key_reg;
                    cur_next       = best_reg;
                    cur_key_next   = best_key_reg;
                    dmem_raddr     = best_reg;
                    state_next     = S_TDEC;
                end
            end

            S_TDEC:
            begin
                if (cnt_cur != '0 && !diff[31] &&
                    ({1'b0, k_reg} + (KW+1)'(size_cur)) <= (KW+1)'(pdpa_pkg::MAX_RESULTS))
                begin
                    n_next     = size_cur;
                    i_next     = '0;
                    tot_next   = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next     = '0;
                    best_ok_next = 1'b0;
                    dmem_raddr   = '0;
                    rd_pend_next = 1'b1;
                    state_next   = S_TSCAN;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer and flip-flop state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            dvalid_reg  <= '0;
            now_reg     <= '0;
            rd_pend_reg <= 1'b0;
            for (int d = 0; d < NUM_DESTINATIONS; d++)
            begin
                qhead_reg[d]  <= '0;
                qcount_reg[d] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
            if (new_entry)
            begin
                dvalid_reg[cur_reg] <= 1'b1;
                qhead_reg[cur_reg]  <= '0;
                qcount_reg[cur_reg] <= CW'(1);
            end
            else if (enq)
            begin
                qcount_reg[cur_reg] <= qcount_reg[cur_reg] + 1'b1;
            end
            if (drain_step)
            begin
                qcount_reg[cur_reg] <= qcount_reg[cur_reg] - 1'b1;
                qhead_reg[cur_reg]  <= (qhead_reg[cur_reg] == QW'(QUEUE_DEPTH - 1)) ?
                                       '0 : qhead_reg[cur_reg] + 1'b1;
            end
            if (state_reg == S_TRD && !best_ok_reg)
            begin
                now_reg <= now_reg + 32'd1;
            end
        end
    end

    // Item payload and working registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            kind_reg <= kind;
            dst_reg  <= dest_address;
            h_reg    <= packet_handle;
            len_reg  <= byte_length;
        end
        idx_reg       <= idx_next;
        found_reg     <= found_next;
        fidx_reg      <= fidx_next;
        free_ok_reg   <= free_ok_next;
        free_reg      <= free_next;
        have_prev_reg <= have_prev_next;
        prev_reg      <= prev_next;
        best_ok_reg   <= best_ok_next;
        best_key_reg  <= best_key_next;
        best_reg      <= best_next;
        cur_reg       <= cur_next;
        cur_key_reg   <= cur_key_next;
        n_reg         <= n_next;
        i_reg         <= i_next;
        tot_reg       <= tot_next;
        k_reg         <= k_next;
    end

endmodule

[bench/pdpa_checker.sv]
// ----------------------------------------------------------------------------
// pdpa_checker
// Watches the input and output channels and the register port of the packet
// aggregator, predicts every result item and compares field by field.
// ----------------------------------------------------------------------------
module pdpa_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        kind,
    input  logic [31:0] dest_address,
    input  logic [15:0] packet_handle,
    input  logic [15:0] byte_length,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] out_dest,
    input  logic [15:0] out_handle,
    input  logic [15:0] out_length,
    input  logic [18:0] total_bytes,
    input  logic        last_of_aggregate,
    input  logic        bundled,
    input  logic [1:0]  status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending_count
);

    localparam int NDEST  = 8;
    localparam int QDEPTH = 8;

    // Shadow copy of the registers and the destination state.
    logic [15:0] delay_q;
    logic [3:0]  agg_max_q;
    logic        slot_used [NDEST];
    logic [31:0] slot_key [NDEST];
    logic [31:0] slot_last [NDEST];
    logic [15:0] hold_handle [NDEST][QDEPTH];
    logic [15:0] hold_length [NDEST][QDEPTH];
    int          q_head [NDEST];
    int          q_count [NDEST];
    logic [31:0] now_q;

    pdpa_pkg::result_t expected_results [$];

    assign pending_count = expected_results.size();

    function automatic int agg_count(int d);
        int m;
        m = (agg_max_q == 0) ? 1 :
            ((agg_max_q > pdpa_pkg::MAX_AGG) ? pdpa_pkg::MAX_AGG : agg_max_q);
        return (q_count[d] < m) ? q_count[d] : m;
    endfunction

    function automatic bit is_due(int d);
        logic [31:0] diff;
        diff = now_q - (slot_last[d] + {16'd0, delay_q});
        return !diff[31];
    endfunction

    // Appends one expected item at the tail.
    function automatic void expect_item(pdpa_pkg::result_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    // Drains one aggregate of destination d into the expectation queue.
    function automatic void emit_aggregate(int d);
        int n;
        logic [18:0] sum;
        pdpa_pkg::result_t r;
        n = agg_count(d);
        sum = '0;
        for (int i = 0; i < n; i++)
        begin
            sum += hold_length[d][q_head[d]];
            r.dest    = slot_key[d];
            r.handle  = hold_handle[d][q_head[d]];
            r.length  = hold_length[d][q_head[d]];
            r.last    = (i == n - 1);
            r.total   = r.last ? sum : '0;
            r.bundled = 1'b1;
            r.status  = pdpa_pkg::STATUS_SENT;
            expect_item(r);
            q_head[d] = (q_head[d] + 1) % QDEPTH;
            q_count[d]--;
        end
        slot_last[d] = now_q;
    endfunction

    function automatic void single_result(logic [31:0] dst, logic [15:0] h,
                                          logic [15:0] len, logic [18:0] tot,
                                          logic [1:0] st);
        pdpa_pkg::result_t r;
        r.dest = dst; r.handle = h; r.length = len; r.total = tot;
        r.last = 1'b1; r.bundled = 1'b0; r.status = st;
        expect_item(r);
    endfunction

    function automatic void predict_tick();
        int emitted;
        bit have_prev;
        logic [31:0] prev;
        int best;
        emitted = 0;
        have_prev = 0;
        prev = '0;
        for (int pass = 0; pass < NDEST; pass++)
        begin
            best = -1;
            for (int d = 0; d < NDEST; d++)
            begin
                if (slot_used[d] && !(have_prev && slot_key[d] <= prev) &&
                    (best < 0 || slot_key[d] < slot_key[best]))
                    best = d;
            end
            if (best < 0) break;
            have_prev = 1;
            prev = slot_key[best];
            if (q_count[best] != 0 && is_due(best) &&
                emitted + agg_count(best) <= pdpa_pkg::MAX_RESULTS)
            begin
                emitted += agg_count(best);
                emit_aggregate(best);
            end
        end
        now_q++;
    endfunction

    function automatic void predict_packet(logic [31:0] dst, logic [15:0] h,
                                           logic [15:0] len);
        int found;
        int free_slot;
        bit send_now;
        logic [31:0] diff;
        int pos;
        found = -1;
        free_slot = -1;
        send_now = 0;
        if (delay_q == 0)
        begin
            single_result(dst, h, len, {3'd0, len}, pdpa_pkg::STATUS_SENT);
            return;
        end
        for (int d = 0; d < NDEST; d++)
        begin
            if (slot_used[d])
            begin
                if (found < 0 && slot_key[d] == dst) found = d;
            end
            else if (free_slot < 0)
            begin
                free_slot = d;
            end
        end
        if (found < 0)
        begin
            if (free_slot < 0)
            begin
                single_result(dst, h, len, '0, pdpa_pkg::STATUS_TABLE_FULL);
                return;
            end
            found = free_slot;
            slot_used[found] = 1'b1;
            slot_key[found]  = dst;
            slot_last[found] = now_q;
            q_head[found]    = 0;
            q_count[found]   = 0;
            send_now = 1;
        end
        else
        begin
            diff = now_q - (slot_last[found] + {16'd0, delay_q});
            send_now = (diff != 0) && !diff[31];
        end
        if (q_count[found] >= QDEPTH)
        begin
            single_result(dst, h, len, '0, pdpa_pkg::STATUS_QUEUE_FULL);
            return;
        end
        pos = (q_head[found] + q_count[found]) % QDEPTH;
        hold_handle[found][pos] = h;
        hold_length[found][pos] = len;
        q_count[found]++;
        if (send_now) emit_aggregate(found);
    endfunction

    // Tracks registers and input items, and checks each result item.
    always @(posedge clk or negedge rst_n)
    begin
        pdpa_pkg::result_t want;
        if (!rst_n)
        begin
            delay_q   = 16'd0;
            agg_max_q = 4'd8;
            now_q     = '0;
            for (int d = 0; d < NDEST; d++)
            begin
                slot_used[d] = 1'b0;
                q_head[d]    = 0;
                q_count[d]   = 0;
            end
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == pdpa_pkg::REG_MAX_AGG) agg_max_q = pwdata[3:0];
                else delay_q = pwdata[15:0];
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with nothing expected: dest %h handle %h",
                           out_dest, out_handle);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (out_dest !== want.dest)
                    begin
                        $error("out_dest: expected %h, got %h", want.dest, out_dest);
                        fail_count = fail_count + 1;
                    end
                    if (out_handle !== want.handle)
                    begin
                        $error("out_handle: expected %h, got %h", want.handle, out_handle);
                        fail_count = fail_count + 1;
                    end
                    if (out_length !== want.length)
                    begin
                        $error("out_length: expected %h, got %h", want.length, out_length);
                        fail_count = fail_count + 1;
                    end
                    if (total_bytes !== want.total)
                    begin
                        $error("total_bytes: expected %h, got %h", want.total, total_bytes);
                        fail_count = fail_count + 1;
                    end
                    if (last_of_aggregate !== want.last)
                    begin
                        $error("last_of_aggregate: expected %b, got %b",
                               want.last, last_of_aggregate);
                        fail_count = fail_count + 1;
                    end
                    if (bundled !== want.bundled)
                    begin
                        $error("bundled: expected %b, got %b", want.bundled, bundled);
                        fail_count = fail_count + 1;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (kind == pdpa_pkg::KIND_TICK) predict_tick();
                else predict_packet(dest_address, packet_handle, byte_length);
            end
        end
    end

endmodule

[bench/tb_per_destination_packet_aggregator_top.sv]
// ----------------------------------------------------------------------------
// tb_per_destination_packet_aggregator_top
// Drives packet and tick items and register writes into the aggregator with
// random bursts and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_per_destination_packet_aggregator_top;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [31:0] dest_address;
    logic [15:0] packet_handle;
    logic [15:0] byte_length;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] out_dest;
    logic [15:0] out_handle;
    logic [15:0] out_length;
    logic [18:0] total_bytes;
    logic        last_of_aggregate;
    logic        bundled;
    logic [1:0]  status;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_count;
    bit          hold_off_req;
    bit          hold_off_done;

    // A small address pool makes destinations repeat and fill the table.
    logic [31:0] addr_pool [10];

    per_destination_packet_aggregator_top u_dut (.*);

    pdpa_checker u_checker (.*);

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #2000000;
        $display("per_destination_packet_aggregator_top regression: fail");
        $finish;
    end

    // Receiver: random stall pattern, plus one long hold-off on request.
    initial
    begin
        int mode;
        out_stall = 1'b0;
        hold_off_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                out_stall <= 1'b0;
                hold_off_done = 1;
            end
            else
            begin
                mode = ($urandom_range(0, 199) < 100) ? 0 : 1;
                out_stall <= (mode == 1) && ($urandom_range(0, 2) == 0);
            end
        end
    end

    task automatic reg_write(logic [0:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offers one item and waits for it to be accepted.
    task automatic send_item(logic k, logic [31:0] dst, logic [15:0] h,
                             logic [15:0] len);
        in_valid      <= 1'b1;
        kind          <= k;
        dest_address  <= dst;
        packet_handle <= h;
        byte_length   <= len;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic idle_gap();
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_count != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic random_items(int count, int tick_pct);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < tick_pct)
                send_item(pdpa_pkg::KIND_TICK, $urandom, 16'($urandom), 16'($urandom));
            else
                send_item(pdpa_pkg::KIND_PACKET, addr_pool[$urandom_range(0, 9)],
                          16'($urandom), 16'($urandom));
            idle_gap();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = pdpa_pkg::KIND_PACKET;
        dest_address = '0;
        packet_handle = '0;
        byte_length = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_off_req = 0;
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 10; i++) addr_pool[i] = $urandom;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pass-through with the reset delay of zero, field extremes.
        send_item(pdpa_pkg::KIND_PACKET, 32'h0, 16'h0, 16'h0);
        send_item(pdpa_pkg::KIND_PACKET, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_item(pdpa_pkg::KIND_TICK, 32'h0, 16'h0, 16'h0);
        drain();

        // Delay of one tick, aggregates of three: queue, tick, queue full.
        reg_write(pdpa_pkg::REG_SEND_DELAY, 32'd1);
        reg_write(pdpa_pkg::REG_MAX_AGG, 32'd3);
        for (int i = 0; i < 10; i++)
            send_item(pdpa_pkg::KIND_PACKET, addr_pool[1], 16'(i), 16'hFFFF - 16'(i));
        for (int i = 0; i < 4; i++) send_item(pdpa_pkg::KIND_TICK, '0, '0, '0);
        // Table full: nine distinct destinations.
        for (int i = 0; i < 9; i++)
            send_item(pdpa_pkg::KIND_PACKET, addr_pool[i + 1] ^ 32'h5A5A_0000,
                      16'(i), 16'(i));
        drain();

        // Aggregate size of zero acts as one; above eight acts as eight.
        reg_write(pdpa_pkg::REG_MAX_AGG, 32'd0);
        random_items(10, 25);
        drain();
        reg_write(pdpa_pkg::REG_MAX_AGG, 32'd15);
        reg_write(pdpa_pkg::REG_SEND_DELAY, 32'd2);
        random_items(25, 20);
        drain();

        // Long hold-off on the output while items keep coming.
        reg_write(pdpa_pkg::REG_SEND_DELAY, 32'd65535);
        reg_write(pdpa_pkg::REG_MAX_AGG, 32'd8);
        hold_off_req = 1;
        random_items(25, 10);
        drain();

        // Maximum aggregate with a short delay, then pass-through again.
        reg_write(pdpa_pkg::REG_SEND_DELAY, 32'd1);
        random_items(30, 30);
        drain();
        reg_write(pdpa_pkg::REG_SEND_DELAY, 32'd0);
        random_items(10, 20);
        drain();

        if (fail_count == 0)
            $display("per_destination_packet_aggregator_top regression: pass");
        else
            $display("per_destination_packet_aggregator_top regression: fail");
        $finish;
    end

endmodule
